[rtl/bedict_pkg.sv]
package bedict_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned EDGE_ID_W       = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch the input beat and its hash
    logic clr;         // write an empty slot during the clearing pass
    logic probe_next;  // step to the next slot
    logic res_hit;     // capture a matching slot as the result
    logic res_new;     // insert the pair (or flag full) and capture the result
    logic out_load;    // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_edge;     // input beat is a taken branch
    logic clr_last;    // clearing pass is at its last slot
    logic hit;         // read slot is valid and holds the pair
    logic empty;       // read slot is free
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

[rtl/branch_edge_id_dictionary_top.sv]
// branch edge id dictionary
//
// input channel: one beat per control transfer (source, target, branch,
// taken, call and return flags) on in_valid_i / in_stall_o. only taken
// branches give a result; other beats are taken and dropped.
// output channel: one beat per taken branch on out_valid_o / out_stall_i
// with the dense edge id, first-seen and table-full marks and the call and
// return flags copied through.
// pairs live in a hash table of 2**(clog2(TABLE_DEPTH)+1) slots in one
// synchronous memory, linear probing. a taken branch is taken in and its
// first probed slot read and compared; a match or an empty slot goes to
// result handoff, else the next slot is read and compared. the probe loop
// sets the rate. the table is at most half full, so probing always ends.
// reset: the controller first sweeps every slot clearing its valid bit,
// one slot a cycle; in_stall_o stays high until the sweep ends. ids
// restart from 0.
// a stalled output holds its beat; the next input beat is still accepted
// and worked on, and waits at the end until the output register is free.

module branch_edge_id_dictionary_top
  import bedict_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_W-1:0]    source_address_i,
  input  logic [ADDR_W-1:0]    target_address_i,
  input  logic                 is_branch_i,
  input  logic                 taken_i,
  input  logic                 is_call_i,
  input  logic                 return_flag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [EDGE_ID_W-1:0] edge_id_o,
  output logic                 first_seen_o,
  output logic                 table_full_o,
  output logic                 call_mark_o,
  output logic                 return_mark_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: clearing sweep, beat intake, probe loop, result handoff
  bedict_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot memory, hash, id counter and output register
  bedict_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .source_address_i (source_address_i),
    .target_address_i (target_address_i),
    .is_branch_i      (is_branch_i),
    .taken_i          (taken_i),
    .is_call_i        (is_call_i),
    .return_flag_i    (return_flag_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .edge_id_o        (edge_id_o),
    .first_seen_o     (first_seen_o),
    .table_full_o     (table_full_o),
    .call_mark_o      (call_mark_o),
    .return_mark_o    (return_mark_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

[rtl/bedict_ctrl.sv]
module bedict_ctrl
  import bedict_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.is_edge) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.hit) begin
          cmd_o.res_hit = 1'b1;
          state_d       = ST_DONE;
        end else if (sts_i.empty) begin
          cmd_o.res_new = 1'b1;
          state_d       = ST_DONE;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = ST_READ;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // a compare always follows a read
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_READ))
    else $error("compare without a preceding read");

  // a probe step always leads to a new read
  a_probe_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.probe_next |=> (state_q == ST_READ))
    else $error("probe step did not issue a read");

  // no input is taken while a result waits for the output register
  a_no_take_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !cmd_o.take)
    else $error("input taken while a result is pending");

endmodule

[rtl/bedict_dp.sv]
module bedict_dp
  import bedict_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ADDR_W-1:0]    source_address_i,
  input  logic [ADDR_W-1:0]    target_address_i,
  input  logic                 is_branch_i,
  input  logic                 taken_i,
  input  logic                 is_call_i,
  input  logic                 return_flag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [EDGE_ID_W-1:0] edge_id_o,
  output logic                 first_seen_o,
  output logic                 table_full_o,
  output logic                 call_mark_o,
  output logic                 return_mark_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W = IDX_W + 1;
  localparam int unsigned KEY_W  = 2 * ADDR_W;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] tgt;
    logic [IDX_W-1:0]  id;
  } slot_t;

  slot_t mem [2**SLOT_W];
  slot_t rd_q;

  logic [ADDR_W-1:0] src_q, tgt_q;
  logic              call_q, ret_q;
  logic [SLOT_W-1:0] addr_q, clr_q;
  logic [CNT_W-1:0]  next_id_q;
  logic [IDX_W-1:0]  res_id_q;
  logic              res_fresh_q, res_full_q, res_call_q, res_ret_q;
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_id_q;
  logic              out_fresh_q, out_full_q, out_call_q, out_ret_q;

  logic [SLOT_W-1:0] hash;
  logic [KEY_W-1:0]  key;
  logic              room;
  logic              we;
  logic [SLOT_W-1:0] wa;
  slot_t             wd;
  logic [IDX_W+EDGE_ID_W-1:0] id_ext;

  // xor fold of the address pair onto the slot index
  always_comb begin
    key  = {target_address_i, source_address_i};
    hash = '0;
    for (int i = 0; i < KEY_W; i++) begin
      hash[i % SLOT_W] = hash[i % SLOT_W] ^ key[i];
    end
  end

  assign room = (next_id_q < CNT_W'(TABLE_DEPTH));

  assign we = cmd_i.clr | (cmd_i.res_new & room);
  assign wa = cmd_i.clr ? clr_q : addr_q;
  always_comb begin
    wd = '0;
    if (!cmd_i.clr) begin
      wd.vld = 1'b1;
      wd.src = src_q;
      wd.tgt = tgt_q;
      wd.id  = next_id_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_q];
  end

  // beat capture and probe address
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      src_q  <= source_address_i;
      tgt_q  <= target_address_i;
      call_q <= is_call_i;
      ret_q  <= return_flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      clr_q     <= '0;
      next_id_q <= '0;
    end else begin
      if (cmd_i.take) begin
        addr_q <= hash;
      end else if (cmd_i.probe_next) begin
        addr_q <= addr_q + 1'b1;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.res_new && room) begin
        next_id_q <= next_id_q + 1'b1;
      end
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_hit) begin
      res_id_q    <= rd_q.id;
      res_fresh_q <= 1'b0;
      res_full_q  <= 1'b0;
      res_call_q  <= call_q;
      res_ret_q   <= ret_q;
    end else if (cmd_i.res_new) begin
      res_id_q    <= room ? next_id_q[IDX_W-1:0] : '0;
      res_fresh_q <= room;
      res_full_q  <= !room;
      res_call_q  <= call_q;
      res_ret_q   <= ret_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_id_q    <= res_id_q;
      out_fresh_q <= res_fresh_q;
      out_full_q  <= res_full_q;
      out_call_q  <= res_call_q;
      out_ret_q   <= res_ret_q;
    end
  end

  assign id_ext        = {{EDGE_ID_W{1'b0}}, out_id_q};
  assign out_valid_o   = out_valid_q;
  assign edge_id_o     = id_ext[EDGE_ID_W-1:0];
  assign first_seen_o  = out_fresh_q;
  assign table_full_o  = out_full_q;
  assign call_mark_o   = out_call_q;
  assign return_mark_o = out_ret_q;

  assign sts_o.is_edge  = is_branch_i & taken_i;
  assign sts_o.clr_last = &clr_q;
  assign sts_o.hit      = rd_q.vld && (rd_q.src == src_q) && (rd_q.tgt == tgt_q);
  assign sts_o.empty    = !rd_q.vld;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  a_id_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q <= CNT_W'(TABLE_DEPTH))
    else $error("id counter ran past the table depth");

  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_new && room) |=> (next_id_q == $past(next_id_q) + 1'b1))
    else $error("insert did not advance the id counter");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !cmd_i.out_load) |=> !out_valid_q)
    else $error("taken result still shown");

endmodule
